// ===== hw/rtl/imrr_pkg.sv =====
// ----------------------------------------------------------------------------
// imrr_pkg: shared types and constants for the input macro recorder/player
// Report and frame layouts, command and mode codes, merge helpers.
// ----------------------------------------------------------------------------
package imrr_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int MAX_FRAMES = 1024;
    localparam int SLOT_W     = 2;
    localparam int FIDX_W     = $clog2(MAX_FRAMES);
    localparam int CNT_W      = FIDX_W + 1;
    localparam int ADDR_W     = SLOT_W + FIDX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [3:0]  HAT_NONE  = 4'd8;
    localparam logic [7:0]  STICK_MID = 8'd128;
    localparam logic [15:0] DELTA_CAP = 16'hFFFF;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_SET   = 3'd1;
    localparam logic [2:0] CMD_REC   = 3'd2;
    localparam logic [2:0] CMD_PRESS = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;

    localparam logic [1:0] PM_SINGLE = 2'd0;
    localparam logic [1:0] PM_RAPID  = 2'd1;
    localparam logic [1:0] PM_CONT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DURATION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAP       = 2'd2;

    typedef struct packed {
        logic [15:0] buttons;
        logic [3:0]  hat;
        logic [7:0]  lx;
        logic [7:0]  ly;
        logic [7:0]  rx;
        logic [7:0]  ry;
    } rpt_t;

    typedef struct packed {
        logic [15:0] delta;
        rpt_t        rpt;
    } frame_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] time_ms;
        rpt_t        pad;
        logic [1:0]  slot;
        logic [1:0]  play_mode;
        logic        slot_held;
    } item_t;

    // what the evaluate step leads into
    typedef enum logic [1:0] {
        EV_DONE  = 2'd0,
        EV_COPY  = 2'd1,
        EV_PLAY  = 2'd2,
        EV_START = 2'd3
    } ev_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic copy_step;
        logic advance;
        logic load_first;
        logic play_fin;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        ev_t  ev;
        logic copy_done;
        logic play_more;
        logic out_free;
    } ctl_sts_t;

    function automatic rpt_t neutral_rpt();
        rpt_t r;
        r.buttons = '0;
        r.hat     = HAT_NONE;
        r.lx      = STICK_MID;
        r.ly      = STICK_MID;
        r.rx      = STICK_MID;
        r.ry      = STICK_MID;
        return r;
    endfunction

    function automatic logic is_neutral(rpt_t r);
        return r == neutral_rpt();
    endfunction

    function automatic logic [7:0] axis_dev(logic [7:0] a);
        return a[7] ? (a - STICK_MID) : (STICK_MID - a);
    endfunction

    function automatic logic [7:0] merge_axis(logic [7:0] pad, logic [7:0] mac);
        return (axis_dev(mac) > axis_dev(pad)) ? mac : pad;
    endfunction

    function automatic rpt_t merge_rpt(rpt_t pad, rpt_t mac);
        rpt_t r;
        r.buttons = pad.buttons | mac.buttons;
        r.hat     = (mac.hat != HAT_NONE) ? mac.hat : pad.hat;
        r.lx      = merge_axis(pad.lx, mac.lx);
        r.ly      = merge_axis(pad.ly, mac.ly);
        r.rx      = merge_axis(pad.rx, mac.rx);
        r.ry      = merge_axis(pad.ry, mac.ry);
        return r;
    endfunction

endpackage

// ===== hw/rtl/imrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// imrr_ctrl: sequencer for the macro recorder/player
// Steps one item through evaluate, slot copy, frame advance or first-frame fetch, and result.
// ----------------------------------------------------------------------------
module imrr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  imrr_pkg::ctl_sts_t sts,
    output imrr_pkg::ctl_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EVAL   = 8'b0000_0010,
        ST_COPY   = 8'b0000_0100,
        ST_PCHK   = 8'b0000_1000,
        ST_PWAIT  = 8'b0001_0000,
        ST_SFETCH = 8'b0010_0000,
        ST_SWAIT  = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                unique case (sts.ev)
                    imrr_pkg::EV_COPY:  state_next = ST_COPY;
                    imrr_pkg::EV_PLAY:  state_next = ST_PCHK;
                    imrr_pkg::EV_START: state_next = ST_SFETCH;
                    default:            state_next = ST_OUT;
                endcase
            end
            ST_COPY: begin
                cmd.copy_step = 1'b1;
                if (sts.copy_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_PCHK: begin
                if (sts.play_more) begin
                    state_next = ST_PWAIT;
                end else begin
                    cmd.play_fin = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_PWAIT: begin
                cmd.advance = 1'b1;
                state_next  = ST_PCHK;
            end
            ST_SFETCH: begin
                state_next = ST_SWAIT;
            end
            ST_SWAIT: begin
                cmd.load_first = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/imrr_dp.sv =====
// ----------------------------------------------------------------------------
// imrr_dp: datapath of the macro recorder/player
// Item register, recording and slot frame memories, playback state, result.
// ----------------------------------------------------------------------------
module imrr_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [imrr_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [imrr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  imrr_pkg::item_t                     s_item,
    input  imrr_pkg::ctl_cmd_t                  cmd,
    output imrr_pkg::ctl_sts_t                  sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output imrr_pkg::rpt_t                      m_rpt,
    output logic [1:0]                          m_mode,
    output logic [1:0]                          m_slot,
    output logic [imrr_pkg::CNT_W-1:0]          m_saved
);

    localparam int CW = imrr_pkg::CNT_W;
    localparam int FW = imrr_pkg::FIDX_W;
    localparam int SN = imrr_pkg::SLOT_COUNT;
    localparam logic [CW-1:0] MAXF = CW'(imrr_pkg::MAX_FRAMES);

    // configuration
    logic [15:0] interval_reg;
    logic [31:0] max_dur_reg;
    logic [15:0] gap_reg;

    // item
    imrr_pkg::item_t it_reg;

    // control state
    logic [1:0]                     mode_reg;
    logic [imrr_pkg::SLOT_W-1:0]    act_reg;
    logic [1:0]                     pm_reg [SN];
    logic [CW-1:0]                  scnt_reg [SN];
    logic [CW-1:0]                  rec_cnt_reg;
    logic [CW-1:0]                  keep_cnt_reg;   // count up to last non-neutral frame
    logic [31:0]                    start_reg;
    logic [31:0]                    lft_reg;
    logic                           first_reg;
    imrr_pkg::rpt_t                 last_reg;
    logic [CW-1:0]                  idx_reg;
    logic [31:0]                    next_reg;
    imrr_pkg::rpt_t                 cur_reg;

    // copy sweep
    logic [CW-1:0]                  copy_n_reg;
    logic [CW-1:0]                  copy_rd_reg;
    logic [FW-1:0]                  copy_wr_reg;
    logic                           wr_pend_reg;

    // memories
    imrr_pkg::frame_t rec_mem  [imrr_pkg::MAX_FRAMES];
    imrr_pkg::frame_t slot_mem [SN * imrr_pkg::MAX_FRAMES];
    imrr_pkg::frame_t rec_rd_reg;
    imrr_pkg::frame_t rda_reg;
    imrr_pkg::frame_t rdb_reg;

    // result staging and output
    imrr_pkg::rpt_t   res_rpt_reg;
    logic [CW-1:0]    res_saved_reg;
    logic             m_valid_reg;
    imrr_pkg::rpt_t   m_rpt_reg;
    logic [1:0]       m_mode_reg;
    logic [1:0]       m_slot_reg;
    logic [CW-1:0]    m_saved_reg;

    // evaluate terms
    imrr_pkg::rpt_t pad;
    logic [31:0]    rec_delta;
    logic [15:0]    delta_sat;
    logic           slot_ok, timeout, tick_rec, skip, bh_chg, st_chg, due, rec_hit;
    logic [CW-1:0]  cnt_after, keep_after, save_n;
    logic           save_now, play_go, start_go;
    logic [1:0]     pm_act;
    logic [CW-1:0]  cnt_act, idx_p1;
    logic [31:0]    play_diff;
    imrr_pkg::ev_t  ev_sel;

    assign pad     = it_reg.pad;
    assign slot_ok = {1'b0, it_reg.slot} < 3'(SN);
    assign pm_act  = pm_reg[act_reg];
    assign cnt_act = scnt_reg[act_reg];
    assign idx_p1  = idx_reg + CW'(1);

    assign timeout   = (mode_reg == imrr_pkg::MODE_REC)
                     && ((it_reg.time_ms - start_reg) >= max_dur_reg);
    assign tick_rec  = !timeout && (it_reg.command == imrr_pkg::CMD_TICK)
                     && (mode_reg == imrr_pkg::MODE_REC);
    assign skip      = !first_reg && imrr_pkg::is_neutral(pad);
    assign rec_delta = it_reg.time_ms - (first_reg ? lft_reg : it_reg.time_ms);
    assign delta_sat = (rec_delta[31:16] != 16'd0) ? imrr_pkg::DELTA_CAP : rec_delta[15:0];
    assign bh_chg    = (pad.buttons != last_reg.buttons) || (pad.hat != last_reg.hat);
    assign st_chg    = (pad.lx != last_reg.lx) || (pad.ly != last_reg.ly)
                     || (pad.rx != last_reg.rx) || (pad.ry != last_reg.ry);
    assign due       = rec_delta >= {16'd0, interval_reg};
    assign rec_hit   = tick_rec && !skip
                     && (bh_chg || (st_chg && due) || (due && !imrr_pkg::is_neutral(pad)));
    assign cnt_after  = rec_cnt_reg + CW'(rec_hit);
    assign keep_after = (rec_hit && !imrr_pkg::is_neutral(pad)) ? cnt_after : keep_cnt_reg;
    assign save_n     = tick_rec ? keep_after : keep_cnt_reg;

    always_comb begin
        save_now = 1'b0;
        if (mode_reg == imrr_pkg::MODE_REC) begin
            priority if (timeout) begin
                save_now = 1'b1;
            end else if (it_reg.command == imrr_pkg::CMD_STOP) begin
                save_now = 1'b1;
            end else if (it_reg.command == imrr_pkg::CMD_PRESS) begin
                save_now = slot_ok && (it_reg.slot == act_reg);
            end else if (it_reg.command == imrr_pkg::CMD_TICK) begin
                save_now = cnt_after >= MAXF;
            end else begin
                save_now = 1'b0;
            end
        end
    end

    assign play_go  = (it_reg.command == imrr_pkg::CMD_TICK) && (mode_reg == imrr_pkg::MODE_PLAY)
                    && !((pm_act == imrr_pkg::PM_RAPID) && !it_reg.slot_held);
    assign start_go = (it_reg.command == imrr_pkg::CMD_PRESS) && (mode_reg == imrr_pkg::MODE_IDLE)
                    && slot_ok && (scnt_reg[it_reg.slot] != '0);

    always_comb begin
        priority if (save_now && (save_n != '0)) begin
            ev_sel = imrr_pkg::EV_COPY;
        end else if (play_go) begin
            ev_sel = imrr_pkg::EV_PLAY;
        end else if (start_go) begin
            ev_sel = imrr_pkg::EV_START;
        end else begin
            ev_sel = imrr_pkg::EV_DONE;
        end
    end

    // frame due when the wrapped difference is not negative
    assign play_diff     = it_reg.time_ms - next_reg;
    assign sts.ev        = ev_sel;
    assign sts.copy_done = (copy_rd_reg == copy_n_reg) && !wr_pend_reg;
    assign sts.play_more = (idx_reg < cnt_act) && !play_diff[31];
    assign sts.out_free  = !m_valid_reg || m_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= 16'd100;
            max_dur_reg  <= 32'd60000;
            gap_reg      <= 16'd100;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                imrr_pkg::CFG_FRAME_INTERVAL: interval_reg <= cfg_wdata[15:0];
                imrr_pkg::CFG_MAX_DURATION:   max_dur_reg  <= cfg_wdata;
                imrr_pkg::CFG_LOOP_GAP:       gap_reg      <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            it_reg <= s_item;
        end
    end

    // main state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= imrr_pkg::MODE_IDLE;
            act_reg      <= '0;
            for (int i = 0; i < SN; i++) begin
                pm_reg[i]   <= imrr_pkg::PM_SINGLE;
                scnt_reg[i] <= '0;
            end
            rec_cnt_reg  <= '0;
            keep_cnt_reg <= '0;
            start_reg    <= '0;
            lft_reg      <= '0;
            first_reg    <= 1'b0;
            last_reg     <= imrr_pkg::neutral_rpt();
            idx_reg      <= '0;
            next_reg     <= '0;
            cur_reg      <= imrr_pkg::neutral_rpt();
            copy_n_reg   <= '0;
            copy_rd_reg  <= '0;
        end else begin
            if (cmd.eval) begin
                if (!timeout) begin
                    unique case (it_reg.command)
                        imrr_pkg::CMD_TICK: begin
                            if (tick_rec) begin
                                if (!first_reg && !skip) begin
                                    first_reg <= 1'b1;
                                    lft_reg   <= it_reg.time_ms;
                                end
                                if (rec_hit) begin
                                    rec_cnt_reg  <= cnt_after;
                                    keep_cnt_reg <= keep_after;
                                    lft_reg      <= it_reg.time_ms;
                                    last_reg     <= pad;
                                end
                            end else if (mode_reg == imrr_pkg::MODE_PLAY && !play_go) begin
                                mode_reg <= imrr_pkg::MODE_IDLE;   // rapid released
                            end
                        end
                        imrr_pkg::CMD_SET: begin
                            if (mode_reg == imrr_pkg::MODE_IDLE && slot_ok
                                && it_reg.play_mode != 2'd3) begin
                                pm_reg[it_reg.slot] <= it_reg.play_mode;
                            end
                        end
                        imrr_pkg::CMD_REC: begin
                            if (mode_reg == imrr_pkg::MODE_IDLE && slot_ok) begin
                                mode_reg     <= imrr_pkg::MODE_REC;
                                act_reg      <= it_reg.slot;
                                rec_cnt_reg  <= '0;
                                keep_cnt_reg <= '0;
                                start_reg    <= it_reg.time_ms;
                                lft_reg      <= it_reg.time_ms;
                                first_reg    <= 1'b0;
                                last_reg     <= imrr_pkg::neutral_rpt();
                            end
                        end
                        imrr_pkg::CMD_PRESS: begin
                            if (start_go) begin
                                mode_reg <= imrr_pkg::MODE_PLAY;
                                act_reg  <= it_reg.slot;
                                idx_reg  <= '0;
                                next_reg <= it_reg.time_ms;
                            end else if (mode_reg == imrr_pkg::MODE_PLAY && slot_ok
                                         && it_reg.slot == act_reg
                                         && pm_reg[it_reg.slot] == imrr_pkg::PM_CONT) begin
                                mode_reg <= imrr_pkg::MODE_IDLE;
                            end
                        end
                        imrr_pkg::CMD_STOP: begin
                            if (mode_reg == imrr_pkg::MODE_PLAY) begin
                                mode_reg <= imrr_pkg::MODE_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                // stop of a recording: trimmed count is keep count
                if (save_now) begin
                    mode_reg    <= imrr_pkg::MODE_IDLE;
                    rec_cnt_reg <= save_n;
                    copy_n_reg  <= save_n;
                    copy_rd_reg <= '0;
                    if (save_n != '0) begin
                        scnt_reg[act_reg] <= save_n;
                    end
                end
            end

            if (cmd.copy_step && copy_rd_reg != copy_n_reg) begin
                copy_rd_reg <= copy_rd_reg + CW'(1);
            end

            if (cmd.advance) begin
                cur_reg <= rda_reg.rpt;
                idx_reg <= idx_p1;
                if (idx_p1 < cnt_act) begin
                    next_reg <= next_reg + {16'd0, rdb_reg.delta};
                end
            end

            if (cmd.load_first) begin
                cur_reg <= rda_reg.rpt;
            end

            if (cmd.play_fin && idx_reg >= cnt_act) begin
                if ((pm_act == imrr_pkg::PM_RAPID && it_reg.slot_held)
                    || pm_act == imrr_pkg::PM_CONT) begin
                    idx_reg  <= '0;
                    next_reg <= it_reg.time_ms + {16'd0, gap_reg};
                    cur_reg  <= imrr_pkg::neutral_rpt();
                end else begin
                    mode_reg <= imrr_pkg::MODE_IDLE;
                end
            end
        end
    end

    // recording memory
    always_ff @(posedge aclk) begin
        if (cmd.eval && rec_hit) begin
            rec_mem[rec_cnt_reg[FW-1:0]] <= '{delta: delta_sat, rpt: pad};
        end
        rec_rd_reg <= rec_mem[copy_rd_reg[FW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= cmd.copy_step && (copy_rd_reg != copy_n_reg);
        end
        copy_wr_reg <= copy_rd_reg[FW-1:0];
    end

    // slot memory: one write port, two read ports (frame and following delta)
    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            slot_mem[{act_reg, copy_wr_reg}] <= rec_rd_reg;
        end
        rda_reg <= slot_mem[{act_reg, idx_reg[FW-1:0]}];
        rdb_reg <= slot_mem[{act_reg, idx_p1[FW-1:0]}];
    end

    // result staging
    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            res_rpt_reg   <= pad;
            res_saved_reg <= save_now ? save_n : '0;
        end
        if (cmd.play_fin) begin
            res_rpt_reg <= (idx_reg != '0) ? imrr_pkg::merge_rpt(pad, cur_reg) : pad;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_rpt_reg   <= res_rpt_reg;
            m_mode_reg  <= mode_reg;
            m_slot_reg  <= act_reg;
            m_saved_reg <= res_saved_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_rpt    = m_rpt_reg;
    assign m_mode   = m_mode_reg;
    assign m_slot   = m_slot_reg;
    assign m_saved  = m_saved_reg;

    a_keep_le_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        keep_cnt_reg <= rec_cnt_reg)
        else $error("trim count above record count");

    a_cnt_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_cnt_reg <= MAXF)
        else $error("record count above capacity");

    a_play_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == imrr_pkg::MODE_PLAY) |-> (cnt_act != '0))
        else $error("playing an empty slot");

endmodule

// ===== hw/rtl/input_macro_record_replay.sv =====
// ----------------------------------------------------------------------------
// input_macro_record_replay: gamepad macro recorder and player
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// One item in, one result item out. Idle passes the pad report through;
// recording stores delta-timed frames in a 1024-entry buffer, and a stop
// trims trailing neutral frames and copies the rest into one of four slot
// areas; playback merges the slot's frames with the live pad. Steps: an
// ordinary item passes capture, evaluate and the result register. A playback
// tick adds a final due check, plus for each frame that falls due a
// registered read of the slot memory and another due check. A press that
// starts playback adds a fetch of the first frame. A stop that saves frames
// adds a copy sweep, one frame per cycle through the memory ports, behind
// the registered read and the write.
// Input is taken again once the result sits in the output register; a
// stalled result holds the next item only at its own output step.
module input_macro_record_replay (
    input  logic         aclk,
    input  logic         aresetn,
    // config
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // time_ms[31:0] pad_buttons[47:32] pad_hat[51:48] pad_lx[59:52]
    // pad_ly[67:60] pad_rx[75:68] pad_ry[83:76] slot[85:84]
    // play_mode[87:86] slot_held[88]
    input  logic [95:0]  s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_buttons[15:0] out_hat[19:16] out_lx[27:20] out_ly[35:28]
    // out_rx[43:36] out_ry[51:44] machine_mode[53:52] current_slot[55:54]
    // saved_count[66:56]
    output logic [71:0]  m_tdata
);

    imrr_pkg::item_t    item;
    imrr_pkg::ctl_cmd_t cmd;
    imrr_pkg::ctl_sts_t sts;
    imrr_pkg::rpt_t     m_rpt;
    logic [1:0]         m_mode;
    logic [1:0]         m_slot;
    logic [imrr_pkg::CNT_W-1:0] m_saved;

    // unpack the input item
    assign item.command     = s_tuser;
    assign item.time_ms     = s_tdata[31:0];
    assign item.pad.buttons = s_tdata[47:32];
    assign item.pad.hat     = s_tdata[51:48];
    assign item.pad.lx      = s_tdata[59:52];
    assign item.pad.ly      = s_tdata[67:60];
    assign item.pad.rx      = s_tdata[75:68];
    assign item.pad.ry      = s_tdata[83:76];
    assign item.slot        = s_tdata[85:84];
    assign item.play_mode   = s_tdata[87:86];
    assign item.slot_held   = s_tdata[88];

    imrr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    imrr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_item    (item),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_rpt     (m_rpt),
        .m_mode    (m_mode),
        .m_slot    (m_slot),
        .m_saved   (m_saved)
    );

    // pack the result item, zero fill to whole bytes
    assign m_tdata = {5'd0, m_saved, m_slot, m_mode, m_rpt.ry, m_rpt.rx,
                      m_rpt.ly, m_rpt.lx, m_rpt.hat, m_rpt.buttons};

endmodule
